@@ hdl/stiru_pkg.sv @@
package stiru_pkg;

	// Command codes
	localparam logic [1:0] CMD_INSERT = 2'd0;
	localparam logic [1:0] CMD_REMOVE = 2'd1;
	localparam logic [1:0] CMD_UPDATE = 2'd2;

	// Status codes
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_FULL      = 2'd1;
	localparam logic [1:0] ST_NOT_FOUND = 2'd2;

	// Field widths
	localparam int ID_W    = 16;
	localparam int ALT_W   = 16;
	localparam int SLOT_W  = 4;
	localparam int COUNT_W = 5;

	// One result, handed from the sequencer to the output register
	typedef struct packed {
		logic [1:0]         status;
		logic [SLOT_W-1:0]  slot;
		logic [ALT_W-1:0]   old_alt;
		logic [COUNT_W-1:0] count;
	} result_t;

endpackage

@@ hdl/slot_table_insert_remove_update.sv @@
// Slot table with insert, remove and update commands.
// Input channel: in_valid/in_stall carry command, flight_id and new_altitude;
// a transfer happens when in_valid is high and in_stall is low.
// Output channel: out_valid/out_stall carry status, slot_index, old_altitude
// and occupied_count; every command gives exactly one result.
// The sequencer scans the slots one per cycle through a single compare unit
// fed by a RAM with registered read; a command stops at the first free or
// matching slot, a miss scans all SLOTS slots, and the unused command code
// skips the scan. One command is processed at a time; the next transfer is
// taken only after the result has entered the output register.
// in_stall is high while a command is in flight.
// Reset clears all valid bits and the occupancy count at once; no clearing
// pass is needed. When the receiver holds out_stall, the result stays put
// and the finished command waits in the sequencer, holding off new input.
module slot_table_insert_remove_update #(
	parameter int SLOTS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  command,
	input  logic [15:0] flight_id,
	input  logic [15:0] new_altitude,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic [3:0]  slot_index,
	output logic [15:0] old_altitude,
	output logic [4:0]  occupied_count
);

	import stiru_pkg::*;

	logic    busy;
	logic    res_valid;
	logic    res_take;
	result_t res;
	logic    out_valid_q;
	result_t out_q;

	stiru_ctrl #(
		.SLOTS (SLOTS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (in_valid && !busy),
		.cmd       (command),
		.id        (flight_id),
		.alt       (new_altitude),
		.busy      (busy),
		.res_valid (res_valid),
		.res_take  (res_take),
		.res       (res)
	);

	assign in_stall = busy;
	assign res_take = !out_valid_q || !out_stall;

	// Output register: load a new result or drop the transferred one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else if (res_take) begin
			out_valid_q <= res_valid;
			if (res_valid) begin
				out_q <= res;
			end
		end
	end

	assign out_valid      = out_valid_q;
	assign status         = out_q.status;
	assign slot_index     = out_q.slot;
	assign old_altitude   = out_q.old_alt;
	assign occupied_count = out_q.count;

	// Accepted command keeps the input side stalled next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input not stalled after a command transfer");

	// Error results carry no slot and no altitude
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ST_FULL || status == ST_NOT_FOUND)
		|-> slot_index == '0 && old_altitude == '0)
		else $error("error result with nonzero slot or altitude");

	// Table full only when every slot is occupied
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_FULL |-> occupied_count == COUNT_W'(SLOTS))
		else $error("table full reported with free slots");

	// Occupancy never exceeds the table size
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && SLOTS < 32 |-> occupied_count <= COUNT_W'(SLOTS))
		else $error("occupancy count above table size");

endmodule

@@ hdl/stiru_ram.sv @@
module stiru_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write one entry, register the read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

@@ hdl/stiru_ctrl.sv @@
module stiru_ctrl #(
	parameter int SLOTS = 16
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic [1:0]              cmd,
	input  logic [15:0]             id,
	input  logic [15:0]             alt,
	output logic                    busy,
	output logic                    res_valid,
	input  logic                    res_take,
	output stiru_pkg::result_t      res
);

	import stiru_pkg::*;

	localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CW = $clog2(SLOTS + 1);
	localparam int DW = ID_W + ALT_W;
	localparam logic [IW-1:0] LAST = IW'(SLOTS - 1);

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_DONE
	} state_t;

	state_t             state_q;
	logic [1:0]         cmd_q;
	logic [ID_W-1:0]    id_q;
	logic [ALT_W-1:0]   alt_q;
	logic [IW-1:0]      idx_q;
	logic               issue_q;
	logic               chk_s1;
	logic [IW-1:0]      idx_s1;
	logic               vld_s1;
	logic [SLOTS-1:0]   valid_q;
	logic [CW-1:0]      count_q;
	result_t            res_q;

	logic               ram_we;
	logic [DW-1:0]      ram_wdata;
	logic [DW-1:0]      ram_rdata;
	logic               hit;
	logic               miss_end;
	logic [CW-1:0]      count_inc;
	logic [CW-1:0]      count_dec;

	// Identifier and altitude store, one slot read per cycle
	stiru_ram #(
		.WIDTH (DW),
		.DEPTH (SLOTS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (idx_s1),
		.wdata (ram_wdata),
		.raddr (idx_q),
		.rdata (ram_rdata)
	);

	// Compare the slot read last cycle
	always_comb begin
		if (cmd_q == CMD_INSERT) begin
			hit = chk_s1 && !vld_s1;
		end else begin
			hit = chk_s1 && vld_s1 && (ram_rdata[DW-1:ALT_W] == id_q);
		end
		miss_end = chk_s1 && !hit && !issue_q;
	end

	// Write back the slot on a hit; remove only touches the valid bit
	assign ram_we    = (state_q == S_SCAN) && hit && (cmd_q != CMD_REMOVE);
	assign ram_wdata = (cmd_q == CMD_INSERT) ? {id_q, {ALT_W{1'b0}}} : {id_q, alt_q};
	assign count_inc = count_q + CW'(1);
	assign count_dec = count_q - CW'(1);

	assign busy      = (state_q != S_IDLE);
	assign res_valid = (state_q == S_DONE);
	assign res       = res_q;

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cmd_q   <= CMD_INSERT;
			id_q    <= '0;
			alt_q   <= '0;
			idx_q   <= '0;
			issue_q <= 1'b0;
			chk_s1  <= 1'b0;
			idx_s1  <= '0;
			vld_s1  <= 1'b0;
			valid_q <= '0;
			count_q <= '0;
			res_q   <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						cmd_q  <= cmd;
						id_q   <= id;
						alt_q  <= alt;
						idx_q  <= '0;
						chk_s1 <= 1'b0;
						if (cmd == CMD_INSERT || cmd == CMD_REMOVE || cmd == CMD_UPDATE) begin
							issue_q <= 1'b1;
							state_q <= S_SCAN;
						end else begin
							// unused command: report the count, change nothing
							res_q.status  <= ST_OK;
							res_q.slot    <= '0;
							res_q.old_alt <= '0;
							res_q.count   <= COUNT_W'(count_q);
							state_q       <= S_DONE;
						end
					end
				end
				S_SCAN: begin
					if (hit) begin
						// stop on the first free or matching slot
						issue_q       <= 1'b0;
						chk_s1        <= 1'b0;
						state_q       <= S_DONE;
						res_q.status  <= ST_OK;
						res_q.slot    <= SLOT_W'(idx_s1);
						case (cmd_q)
							CMD_INSERT: begin
								valid_q[idx_s1] <= 1'b1;
								count_q         <= count_inc;
								res_q.old_alt   <= '0;
								res_q.count     <= COUNT_W'(count_inc);
							end
							CMD_REMOVE: begin
								valid_q[idx_s1] <= 1'b0;
								count_q         <= count_dec;
								res_q.old_alt   <= ram_rdata[ALT_W-1:0];
								res_q.count     <= COUNT_W'(count_dec);
							end
							default: begin
								res_q.old_alt <= ram_rdata[ALT_W-1:0];
								res_q.count   <= COUNT_W'(count_q);
							end
						endcase
					end else begin
						// advance the read address
						chk_s1 <= issue_q;
						if (issue_q) begin
							idx_s1 <= idx_q;
							vld_s1 <= valid_q[idx_q];
							if (idx_q == LAST) begin
								issue_q <= 1'b0;
							end else begin
								idx_q <= idx_q + IW'(1);
							end
						end
						if (miss_end) begin
							state_q       <= S_DONE;
							res_q.status  <= (cmd_q == CMD_INSERT) ? ST_FULL : ST_NOT_FOUND;
							res_q.slot    <= '0;
							res_q.old_alt <= '0;
							res_q.count   <= COUNT_W'(count_q);
						end
					end
				end
				S_DONE: begin
					if (res_take) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule
